// File: rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared codes and widths for the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] cmd_t;

	localparam cmd_t CMD_PUT     = 3'd0;
	localparam cmd_t CMD_SET_CUR = 3'd1;
	localparam cmd_t CMD_SET_COL = 3'd2;
	localparam cmd_t CMD_CLEAR   = 3'd3;
	localparam cmd_t CMD_READ    = 3'd4;

	localparam byte_t CHAR_BLANK   = 8'h20;
	localparam byte_t CHAR_NEWLINE = 8'h0A;
	localparam byte_t CHAR_RETURN  = 8'h0D;

	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 40;

endpackage

// File: rtl/text_console_cell_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit
// Text-mode console cell store with cursor, color and rotating scroll.
// ----------------------------------------------------------------------------
// Commands arrive on the s_* stream (command in s_tuser) and each one gives
// exactly one result transaction on the m_* stream. s_tready is high only
// while the sequencer is idle; a finished result waits in the output
// register, so the next command is taken while the receiver stalls, and the
// sequencer holds that command's result until the output register is free.
// Sequencer states per command, with the receiver ready:
//   set cursor, set colour, newline, carriage return, unused codes: ST_FIN
//   put of a printable byte without scrolling: ST_WRITE
//   read cell: ST_READ (registered memory read), ST_READW (capture), ST_FIN
//   each scroll step: min(VISIBLE_COLUMNS, LINE_STRIDE) characters blanked, one cell per
//   cycle through the single memory write port
//   clear: TEXT_LINES * LINE_STRIDE cells, one cell per cycle, then ST_FIN
// After reset the block sweeps the whole store to spaces and zero
// attributes, with s_tready low.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit #(
	parameter int TEXT_LINES      = 8,
	parameter int VISIBLE_COLUMNS = 20,
	parameter int LINE_STRIDE     = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// char_code[7:0], color[15:8], column[23:16], row[31:24]
	input  logic [tccw_pkg::IN_DATA_W-1:0]    s_tdata,
	// command[2:0]
	input  logic [tccw_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// read_char[7:0], read_attr[15:8], cursor_col[24:16], cursor_row[32:25],
	// zero padding[39:33]
	output logic [tccw_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int CELLS = TEXT_LINES * LINE_STRIDE;
	localparam int AW    = $clog2(CELLS);
	localparam int LW    = (TEXT_LINES > 1) ? $clog2(TEXT_LINES) : 1;
	localparam int AXW   = AW + 9;
	localparam int NB    = (VISIBLE_COLUMNS < LINE_STRIDE) ? VISIBLE_COLUMNS : LINE_STRIDE;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_INIT   = 3'd1;
	localparam logic [2:0] ST_CLEAR  = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_WRITE  = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;
	localparam logic [2:0] ST_READW  = 3'd6;
	localparam logic [2:0] ST_FIN    = 3'd7;

	logic [2:0]      state_q;
	logic [AW-1:0]   clr_q;
	logic [7:0]      scol_q;
	logic [8:0]      col_q;
	logic [7:0]      line_q;
	logic [7:0]      color_q;
	logic [LW-1:0]   top_q;
	logic            out_valid_q;

	logic [7:0]      ch_q;
	logic [7:0]      rcol_q;
	logic [7:0]      rrow_q;
	logic            rd_ok_q;
	logic [7:0]      res_char_q;
	logic [7:0]      res_attr_q;
	logic [7:0]      out_char_q;
	logic [7:0]      out_attr_q;
	logic [8:0]      out_col_q;
	logic [7:0]      out_row_q;

	logic [7:0]      char_mem [CELLS];
	logic [7:0]      attr_mem [CELLS];
	logic [7:0]      rchar_q;
	logic [7:0]      rattr_q;

	logic            cwe;
	logic            awe;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;
	logic [7:0]      wchar;
	logic [7:0]      wattr;

	logic            accept;
	logic            out_free;
	logic            out_load;
	logic            col_ok;
	logic [8:0]      col_next;
	logic [LW-1:0]   top_next;
	logic [7:0]      in_char;
	logic [7:0]      in_color;
	logic [7:0]      in_column;
	logic [7:0]      in_row;

	function automatic logic [AW-1:0] cell_addr(input logic [LW-1:0] top,
		input logic [LW-1:0] line, input logic [7:0] col);
		logic [LW:0]    sum;
		logic [LW:0]    phys;
		logic [AXW-1:0] wide;
		sum  = {1'b0, top} + {1'b0, line};
		phys = (sum >= (LW+1)'(TEXT_LINES)) ? sum - (LW+1)'(TEXT_LINES) : sum;
		wide = AXW'(phys) * AXW'(LINE_STRIDE) + AXW'(col);
		return wide[AW-1:0];
	endfunction

	assign in_char   = s_tdata[7:0];
	assign in_color  = s_tdata[15:8];
	assign in_column = s_tdata[23:16];
	assign in_row    = s_tdata[31:24];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = ((state_q == ST_WRITE) || (state_q == ST_FIN)) && out_free;
	assign col_ok   = (col_q < 9'(LINE_STRIDE));
	assign col_next = col_ok ? col_q + 9'd1 : col_q;
	assign top_next = (top_q == LW'(TEXT_LINES - 1)) ? '0 : top_q + LW'(1);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_row_q, out_col_q, out_attr_q, out_char_q};

	always_comb begin
		cwe   = 1'b0;
		awe   = 1'b0;
		waddr = clr_q;
		wchar = tccw_pkg::CHAR_BLANK;
		wattr = 8'd0;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				cwe = 1'b1;
				awe = 1'b1;
			end
			ST_SCROLL: begin
				cwe   = 1'b1;
				waddr = cell_addr(top_q, '0, scol_q);
			end
			ST_WRITE: begin
				cwe   = col_ok;
				awe   = col_ok;
				waddr = cell_addr(top_q, line_q[LW-1:0], col_q[7:0]);
				wchar = ch_q;
				wattr = color_q;
			end
			default: begin
			end
		endcase
		raddr = cell_addr(top_q, rrow_q[LW-1:0], rcol_q);
	end

	always_ff @(posedge clk) begin
		if (cwe)
			char_mem[waddr] <= wchar;
		if (awe)
			attr_mem[waddr] <= wattr;
		rchar_q <= char_mem[raddr];
		rattr_q <= attr_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_q       <= '0;
			scol_q      <= 8'd0;
			col_q       <= 9'd0;
			line_q      <= 8'd0;
			color_q     <= 8'd0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !out_load)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							tccw_pkg::CMD_PUT: begin
								if (in_char == tccw_pkg::CHAR_NEWLINE) begin
									if (line_q != 8'd255)
										line_q <= line_q + 8'd1;
									col_q   <= 9'd0;
									state_q <= ST_FIN;
								end else if (in_char == tccw_pkg::CHAR_RETURN) begin
									col_q   <= 9'd0;
									state_q <= ST_FIN;
								end else if (line_q >= 8'(TEXT_LINES)) begin
									scol_q  <= 8'd0;
									state_q <= ST_SCROLL;
								end else begin
									state_q <= ST_WRITE;
								end
							end
							tccw_pkg::CMD_SET_CUR: begin
								col_q   <= {1'b0, in_column};
								line_q  <= in_row;
								color_q <= in_color;
								state_q <= ST_FIN;
							end
							tccw_pkg::CMD_SET_COL: begin
								color_q <= in_color;
								state_q <= ST_FIN;
							end
							tccw_pkg::CMD_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							tccw_pkg::CMD_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_INIT: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1))
						state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						col_q   <= 9'd0;
						line_q  <= 8'd0;
						state_q <= ST_FIN;
					end
				end
				ST_SCROLL: begin
					if (scol_q == 8'(NB - 1)) begin
						scol_q <= 8'd0;
						top_q  <= top_next;
						line_q <= line_q - 8'd1;
						if ((line_q - 8'd1) < 8'(TEXT_LINES))
							state_q <= ST_WRITE;
					end else begin
						scol_q <= scol_q + 8'd1;
					end
				end
				ST_WRITE: begin
					col_q <= col_next;
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_READ: begin
					state_q <= ST_READW;
				end
				ST_READW: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q       <= in_char;
			rcol_q     <= in_column;
			rrow_q     <= in_row;
			rd_ok_q    <= (in_row < 8'(TEXT_LINES)) && ({1'b0, in_column} < 9'(LINE_STRIDE));
			res_char_q <= 8'd0;
			res_attr_q <= 8'd0;
		end
		if (state_q == ST_READW) begin
			res_char_q <= rd_ok_q ? rchar_q : 8'd0;
			res_attr_q <= rd_ok_q ? rattr_q : 8'd0;
		end
		if (state_q == ST_WRITE && out_free) begin
			out_char_q <= 8'd0;
			out_attr_q <= 8'd0;
			out_col_q  <= col_next;
			out_row_q  <= line_q;
		end
		if (state_q == ST_FIN && out_free) begin
			out_char_q <= res_char_q;
			out_attr_q <= res_attr_q;
			out_col_q  <= col_q;
			out_row_q  <= line_q;
		end
	end

	a_scroll_only_past_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCROLL |-> line_q >= 8'(TEXT_LINES))
		else $error("scroll step with the cursor row inside the screen");

	a_write_inside_screen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> line_q < 8'(TEXT_LINES))
		else $error("cell write with the cursor row past the last line");

	a_top_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(top_q) < TEXT_LINES)
		else $error("top line pointer out of range");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != ST_IDLE && !s_tready)
		else $error("sequencer stayed idle after taking a command");

	a_result_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_WRITE || $past(state_q) == ST_FIN)
		else $error("result raised outside a finishing state");

endmodule
